### rtl/descriptor_slot_allocator_unit_assert.svh
// Assertion helpers used by the checker file of this block.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("descriptor slot allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("descriptor slot allocator check failed");

`endif

### rtl/dsa_pkg.sv
package dsa_pkg;

   localparam logic [1:0] ACTION_ALLOC = 2'd0;
   localparam logic [1:0] ACTION_FREE  = 2'd1;
   localparam logic [1:0] ACTION_LINK  = 2'd2;

   localparam int GROUP_SIZE = 32;
   localparam int GROUP_BITS = 5;
   localparam int CMD_DEPTH  = 2;
   localparam int RSP_DEPTH  = 2;

   localparam logic [8:0] ACTIVE_SIZE_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_LINK,
      OP_ACK
   } op_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SCAN,
      BACK_WALK,
      BACK_ACK
   } back_state_type;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] count;
      logic [7:0] slot_index;
      logic [7:0] next_slot;
      logic       chained;
   } req_type;

   typedef struct packed {
      logic [7:0] granted_slot;
      logic       fail;
      logic       last;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] count;
      logic [7:0] slot_index;
      logic [7:0] next_slot;
      logic       chained;
   } cmd_type;

endpackage

### rtl/descriptor_slot_allocator_unit.sv
// Channel   Ports                              Transaction
// request   push, full, req_payload            push && !full
// response  pop, empty, rsp_payload            pop && !empty
// csr       csr_wr_en, csr_wr_data             csr_wr_en
//
// A request is registered in the command queue, and the engine takes it from there.
// Allocate: the engine scans 32-slot groups in order and grants one slot per step; groups
// are not revisited in a run, and a fail ends the run. Free: each visited slot is cleared,
// following the link memory read, then acked. Link and other codes respond from idle.
// Reset is synchronous and clears all marks at once. Outside a free walk the engine stalls
// while the response queue is full; requests still enter the queue.
module descriptor_slot_allocator_unit #(
   parameter int SLOT_COUNT  = 256,
   parameter int MAX_REQUEST = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  dsa_pkg::req_type req_payload,
   output logic             empty,
   input  logic             pop,
   output dsa_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [8:0]       csr_wr_data
);

   logic [8:0]       active_size_ff, active_size_in;
   logic             cmd_valid;
   logic             cmd_pop;
   dsa_pkg::cmd_type cmd;
   logic             rsp_push;
   logic             rsp_full;
   dsa_pkg::rsp_type rsp_data;

   assign active_size_in = csr_wr_en ? csr_wr_data : active_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= dsa_pkg::ACTIVE_SIZE_RESET;
      end else begin
         active_size_ff <= active_size_in;
      end
   end

   dsa_front #(
      .SLOT_COUNT  (SLOT_COUNT),
      .MAX_REQUEST (MAX_REQUEST)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd         (cmd)
   );

   dsa_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .active_size (active_size_ff),
      .rsp_ready   (!rsp_full),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_data)
   );

   dsa_fifo #(
      .ENTRY_TYPE (dsa_pkg::rsp_type),
      .DEPTH      (dsa_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_payload),
      .empty     (empty)
   );

endmodule

### rtl/dsa_fifo.sv
module dsa_fifo #(
   parameter type ENTRY_TYPE = logic,
   parameter int  DEPTH      = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  ENTRY_TYPE push_data,
   output logic      full,
   input  logic      pop,
   output ENTRY_TYPE pop_data,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ENTRY_TYPE        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/dsa_front.sv
module dsa_front #(
   parameter int SLOT_COUNT  = 256,
   parameter int MAX_REQUEST = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  dsa_pkg::req_type req_payload,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output dsa_pkg::cmd_type cmd
);

   dsa_pkg::cmd_type cmd_new;
   logic             keep;
   logic             cmd_empty;

   always_comb begin
      cmd_new.op         = dsa_pkg::OP_ACK;
      cmd_new.count      = req_payload.count;
      cmd_new.slot_index = req_payload.slot_index;
      cmd_new.next_slot  = req_payload.next_slot;
      cmd_new.chained    = req_payload.chained;
      keep               = 1'b1;
      case (req_payload.action)
         dsa_pkg::ACTION_ALLOC: begin
            cmd_new.op = dsa_pkg::OP_ALLOC;
            // A request for no slots is not queued and produces no response.
            if (req_payload.count == 5'd0) begin
               keep = 1'b0;
            end
            if (32'(req_payload.count) > MAX_REQUEST) begin
               cmd_new.count = 5'(MAX_REQUEST);
            end
         end
         dsa_pkg::ACTION_FREE: begin
            cmd_new.op = dsa_pkg::OP_FREE;
         end
         dsa_pkg::ACTION_LINK: begin
            if (32'(req_payload.slot_index) < SLOT_COUNT) begin
               cmd_new.op = dsa_pkg::OP_LINK;
            end
         end
         default: begin
            cmd_new.op = dsa_pkg::OP_ACK;
         end
      endcase
   end

   dsa_fifo #(
      .ENTRY_TYPE (dsa_pkg::cmd_type),
      .DEPTH      (dsa_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push && keep),
      .push_data (cmd_new),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (cmd),
      .empty     (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

### rtl/dsa_back.sv
module dsa_back #(
   parameter int SLOT_COUNT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  dsa_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic [8:0]       active_size,
   input  logic             rsp_ready,
   output logic             rsp_push,
   output dsa_pkg::rsp_type rsp_data
);

   localparam int GB     = dsa_pkg::GROUP_BITS;
   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int NGROUP = (SLOT_COUNT + dsa_pkg::GROUP_SIZE - 1) / dsa_pkg::GROUP_SIZE;
   localparam int GRP_W  = (NGROUP > 1) ? $clog2(NGROUP) : 1;
   localparam int PAD_W  = NGROUP * dsa_pkg::GROUP_SIZE;
   localparam int SZ_W   = ($clog2(SLOT_COUNT + 1) > 9) ? $clog2(SLOT_COUNT + 1) : 9;
   localparam int POS_W  = GRP_W + GB;

   dsa_pkg::back_state_type state_ff, state_in;
   logic [SLOT_COUNT-1:0]   busy_ff, busy_in;
   logic [SLOT_COUNT-1:0]   chain_ff, chain_in;
   logic [GRP_W-1:0]        group_ff, group_in;
   logic [4:0]              remain_ff, remain_in;
   logic [7:0]              head_ff, head_in;
   logic                    first_ff, first_in;
   logic [SZ_W-1:0]         steps_ff, steps_in;

   logic [7:0]              link_mem [SLOT_COUNT];
   logic [7:0]              link_rd_ff;
   logic                    link_rd_en;
   logic                    link_wr_en;

   logic [SZ_W-1:0]         size_eff;
   logic [PAD_W-1:0]        busy_pad;
   logic [dsa_pkg::GROUP_SIZE-1:0] free_bits;
   logic                    found;
   logic [GB-1:0]           pos;
   logic [POS_W-1:0]        grant_pos;
   logic [IDX_W-1:0]        grant_idx;
   logic                    group_end;
   logic [7:0]              cur;
   logic                    cur_ok;
   logic [IDX_W-1:0]        cur_idx;
   logic [SZ_W-1:0]         steps_next;
   logic [IDX_W-1:0]        link_idx;

   always_comb begin
      if (active_size == 9'd0) begin
         size_eff = SZ_W'(1);
      end else if (32'(active_size) > SLOT_COUNT) begin
         size_eff = SZ_W'(SLOT_COUNT);
      end else begin
         size_eff = SZ_W'(active_size);
      end
   end

   always_comb begin
      busy_pad                   = '1;
      busy_pad[SLOT_COUNT-1:0]   = busy_ff;
   end

   always_comb begin
      logic [POS_W-1:0] slot_pos;
      for (int k = 0; k < dsa_pkg::GROUP_SIZE; k++) begin
         slot_pos     = {group_ff, GB'(k)};
         free_bits[k] = !busy_pad[slot_pos] && (32'(slot_pos) < 32'(size_eff));
      end
   end

   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int k = dsa_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
         if (free_bits[k]) begin
            found = 1'b1;
            pos   = GB'(k);
         end
      end
   end

   assign grant_pos  = {group_ff, pos};
   assign grant_idx  = IDX_W'(grant_pos);
   assign group_end  = (32'({group_ff, GB'(0)}) + dsa_pkg::GROUP_SIZE) >= 32'(size_eff);

   assign cur        = first_ff ? head_ff : link_rd_ff;
   assign cur_ok     = 32'(cur) < SLOT_COUNT;
   assign cur_idx    = IDX_W'(cur);
   assign steps_next = steps_ff + 1'b1;
   assign link_idx   = IDX_W'(cmd.slot_index);

   always_comb begin
      state_in   = state_ff;
      busy_in    = busy_ff;
      chain_in   = chain_ff;
      group_in   = group_ff;
      remain_in  = remain_ff;
      head_in    = head_ff;
      first_in   = first_ff;
      steps_in   = steps_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp_data   = '0;
      link_rd_en = 1'b0;
      link_wr_en = 1'b0;
      case (state_ff)
         dsa_pkg::BACK_IDLE: begin
            if (cmd_valid && rsp_ready) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  dsa_pkg::OP_ALLOC: begin
                     group_in  = '0;
                     remain_in = cmd.count;
                     state_in  = dsa_pkg::BACK_SCAN;
                  end
                  dsa_pkg::OP_FREE: begin
                     head_in  = cmd.slot_index;
                     first_in = 1'b1;
                     steps_in = '0;
                     state_in = dsa_pkg::BACK_WALK;
                  end
                  dsa_pkg::OP_LINK: begin
                     chain_in[link_idx] = cmd.chained;
                     link_wr_en         = 1'b1;
                     rsp_push           = 1'b1;
                     rsp_data.last      = 1'b1;
                  end
                  default: begin
                     rsp_push      = 1'b1;
                     rsp_data.last = 1'b1;
                  end
               endcase
            end
         end
         dsa_pkg::BACK_SCAN: begin
            if (rsp_ready) begin
               if (found) begin
                  // Every slot below a grant is busy, so the run resumes in this group.
                  busy_in[grant_idx]    = 1'b1;
                  rsp_push              = 1'b1;
                  rsp_data.granted_slot = 8'(grant_pos);
                  rsp_data.last         = (remain_ff == 5'd1);
                  remain_in             = remain_ff - 1'b1;
                  if (remain_ff == 5'd1) begin
                     state_in = dsa_pkg::BACK_IDLE;
                  end
               end else if (group_end) begin
                  rsp_push      = 1'b1;
                  rsp_data.fail = 1'b1;
                  rsp_data.last = 1'b1;
                  state_in      = dsa_pkg::BACK_IDLE;
               end else begin
                  group_in = group_ff + 1'b1;
               end
            end
         end
         dsa_pkg::BACK_WALK: begin
            if (!cur_ok) begin
               state_in = dsa_pkg::BACK_ACK;
            end else begin
               busy_in[cur_idx] = 1'b0;
               steps_in         = steps_next;
               if (!chain_ff[cur_idx] || (steps_next >= size_eff)) begin
                  state_in = dsa_pkg::BACK_ACK;
               end else begin
                  link_rd_en = 1'b1;
                  first_in   = 1'b0;
               end
            end
         end
         dsa_pkg::BACK_ACK: begin
            if (rsp_ready) begin
               rsp_push      = 1'b1;
               rsp_data.last = 1'b1;
               state_in      = dsa_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = dsa_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsa_pkg::BACK_IDLE;
         busy_ff  <= '0;
         chain_ff <= '0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff  <= group_in;
      remain_ff <= remain_in;
      head_ff   <= head_in;
      first_ff  <= first_in;
      steps_ff  <= steps_in;
   end

   always_ff @(posedge clock) begin
      if (link_wr_en) begin
         link_mem[link_idx] <= cmd.next_slot;
      end
      if (link_rd_en) begin
         link_rd_ff <= link_mem[cur_idx];
      end
   end

endmodule

### rtl/dsa_checker.sv
`include "descriptor_slot_allocator_unit_assert.svh"

module dsa_checker (
   input logic             clock,
   input logic             reset,
   input logic             push,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input dsa_pkg::rsp_type rsp_payload
);

   logic fail_form_ok;

   assign fail_form_ok = rsp_payload.last && (rsp_payload.granted_slot == 8'd0);

   // Both queues come out of reset empty.
   `DSA_ASSERT_IMPLY(a_reset_clears, clock, reset, $past(reset), empty && !full)

   // A failed allocation never carries a slot index and always ends the run.
   `DSA_ASSERT_IMPLY(a_fail_form, clock, reset, !empty && rsp_payload.fail, fail_form_ok)

   `DSA_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_payload))

   // The request queue only fills through an accepted transaction.
   `DSA_ASSERT_NEXT(a_full_needs_push, clock, reset, !full && !push, !full)

endmodule

bind descriptor_slot_allocator_unit dsa_checker u_checker (.*);
